// ===== src/lca_pkg.sv =====
package lca_pkg;

   // Operand selection of the shared multiplier
   typedef enum logic {
      MUL_SEL_RANGE,
      MUL_SEL_TEN
   } mul_sel_type;

   typedef struct packed {
      logic        enable;
      mul_sel_type sel;
   } mul_ctrl_type;

   // Supported ADC resolutions, held as a two-bit code
   typedef enum logic [1:0] {
      RES_4,
      RES_8,
      RES_12,
      RES_16
   } res_code_type;

   // Register indexes on the configuration channel
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOLUTION   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_PRESET = 1'b1;

   // Field widths
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned PRODUCT_W = 32;
   localparam int unsigned WHOLE_W   = 28;
   localparam int unsigned TENTH_W   = 4;
   localparam int unsigned RANGE_W   = 2;
   localparam int unsigned FRAC_W    = 16;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 2'd1;
   localparam logic [RANGE_W-1:0] RANGE_TOP   = 2'd3;
   localparam res_code_type       RES_RESET   = RES_12;
   localparam logic [TENTH_W-1:0] TENTH_MAX   = 4'd9;
   localparam logic [COUNT_W-1:0] TENTH_SCALE = 16'd10;

   // Largest whole lux w with w + w/5 still within a range: ceil(5 * range / 6)
   localparam logic [WHOLE_W-1:0] FIT_1000  = 28'((5 * 1000 + 5) / 6);
   localparam logic [WHOLE_W-1:0] FIT_4000  = 28'((5 * 4000 + 5) / 6);
   localparam logic [WHOLE_W-1:0] FIT_16000 = 28'((5 * 16000 + 5) / 6);

   // Full-scale lux of each range index
   function automatic logic [COUNT_W-1:0] range_lux(input logic [RANGE_W-1:0] idx);
      logic [COUNT_W-1:0] lux;
      unique case (idx)
         2'd0:    lux = 16'd1000;
         2'd1:    lux = 16'd4000;
         2'd2:    lux = 16'd16000;
         default: lux = 16'd64000;
      endcase
      return lux;
   endfunction

   // Shift right by the selected resolution
   function automatic logic [PRODUCT_W-1:0] shr_res(input logic [PRODUCT_W-1:0] v,
                                                    input res_code_type code);
      logic [PRODUCT_W-1:0] r;
      unique case (code)
         RES_4:   r = v >> 4;
         RES_8:   r = v >> 8;
         RES_12:  r = v >> 12;
         default: r = v >> 16;
      endcase
      return r;
   endfunction

endpackage

// ===== src/lca_mul_unit.sv =====
module lca_mul_unit (
   input  logic                                clock,
   input  lca_pkg::mul_ctrl_type               ctrl,
   input  logic [lca_pkg::COUNT_W-1:0]         count,
   input  logic [lca_pkg::RANGE_W-1:0]         range_idx,
   output logic [lca_pkg::PRODUCT_W-1:0]       product
);
   import lca_pkg::*;

   logic [PRODUCT_W-1:0] product_ff;
   logic [PRODUCT_W-1:0] product_in;
   logic [COUNT_W-1:0]   op_a;
   logic [COUNT_W-1:0]   op_b;

   // Pick operands: count by range, or the low half of the last product by ten
   always_comb begin
      unique case (ctrl.sel)
         MUL_SEL_RANGE: begin
            op_a = count;
            op_b = range_lux(range_idx);
         end
         default: begin
            op_a = product_ff[FRAC_W-1:0];
            op_b = TENTH_SCALE;
         end
      endcase
      product_in = PRODUCT_W'(op_a) * PRODUCT_W'(op_b);
   end

   // Hold the product until the next enabled step
   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== src/lux_convert_auto_range_core.sv =====
// Lux conversion with automatic range selection. Each raw count on req_ is
// scaled by the current full-scale range (1000, 4000, 16000 or 64000 lux),
// shifted down by the ADC resolution into whole lux and a tenth digit, and
// the range for later counts is moved to the smallest one that holds the
// result plus a fifth. A zero count gives valid_res low and leaves the range
// alone. After an input transfer req_tready stays low through the states
// ST_MUL_P, ST_MUL_T and ST_FINISH: two passes through the one shared 16x16
// multiplier (count times range, then fraction times ten) and a finishing
// step, so no new count is taken before the result of the last one is
// registered on rsp_. A result held back on rsp_ stalls the finishing
// cycle. Configuration writes are taken only while the block is idle.
module lux_convert_auto_range_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: raw_count[15:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,
   // rsp_tdata: lux_whole[27:0], lux_tenth[31:28], next_range[33:32], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,
   // rsp_tuser: valid_res[0]
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lca_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lca_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_T,
      ST_FINISH
   } state_type;

   state_type            state_ff;
   logic [RANGE_W-1:0]   range_ff;
   res_code_type         res_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [WHOLE_W-1:0]   whole_ff;
   logic                 rsp_valid_ff;
   logic [39:0]          rsp_data_ff;
   logic                 rsp_user_ff;

   mul_ctrl_type         mul_ctrl;
   logic [PRODUCT_W-1:0] product;
   logic [PRODUCT_W-1:0] whole_full;
   logic [PRODUCT_W-1:0] tenth_full;
   logic [TENTH_W-1:0]   tenth;
   logic [RANGE_W-1:0]   range_in;
   logic                 count_zero;
   logic                 req_xfer;
   logic                 csr_xfer;
   logic                 rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign count_zero = (count_ff == '0);

   // Drive the shared multiplier from the sequencer
   always_comb begin
      mul_ctrl.enable = (state_ff == ST_MUL_P) || (state_ff == ST_MUL_T);
      mul_ctrl.sel    = (state_ff == ST_MUL_T) ? MUL_SEL_TEN : MUL_SEL_RANGE;
   end

   lca_mul_unit u_mul (
      .clock     (clock),
      .ctrl      (mul_ctrl),
      .count     (count_ff),
      .range_idx (range_ff),
      .product   (product)
   );

   // Whole lux from the scaled product
   assign whole_full = shr_res(product, res_ff);

   // Tenth digit from the scaled fraction, saturated
   always_comb begin
      tenth_full = shr_res(product, res_ff);
      tenth      = (tenth_full > PRODUCT_W'(TENTH_MAX)) ? TENTH_MAX
                                                        : tenth_full[TENTH_W-1:0];
   end

   // Pick the smallest range holding whole lux plus a fifth
   always_comb begin
      priority if (whole_ff <= FIT_1000) begin
         range_in = 2'd0;
      end else if (whole_ff <= FIT_4000) begin
         range_in = 2'd1;
      end else if (whole_ff <= FIT_16000) begin
         range_in = 2'd2;
      end else begin
         range_in = RANGE_TOP;
      end
   end

   // Sequencer, range state, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= RANGE_RESET;
         res_ff       <= RES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken result; the finishing cycle refills the register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  count_ff <= req_tdata;
                  state_ff <= ST_MUL_P;
               end
            end
            ST_MUL_P: begin
               state_ff <= ST_MUL_T;
            end
            ST_MUL_T: begin
               // product still holds count times range here
               whole_ff <= whole_full[WHOLE_W-1:0];
               state_ff <= ST_FINISH;
            end
            default: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (count_zero) begin
                     rsp_data_ff <= {6'd0, range_ff, 32'd0};
                     rsp_user_ff <= 1'b0;
                  end else begin
                     rsp_data_ff <= {6'd0, range_in, tenth, whole_ff};
                     rsp_user_ff <= 1'b1;
                     range_ff    <= range_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
         endcase

         // Apply configuration writes; unsupported resolutions are dropped
         if (csr_xfer) begin
            unique case (csr_index)
               CSR_RESOLUTION: begin
                  unique case (csr_data)
                     5'd4:    res_ff <= RES_4;
                     5'd8:    res_ff <= RES_8;
                     5'd12:   res_ff <= RES_12;
                     5'd16:   res_ff <= RES_16;
                     default: res_ff <= res_ff;
                  endcase
               end
               default: begin
                  range_ff <= csr_data[RANGE_W-1:0];
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A rejected reading carries no lux
   a_zero_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("rejected reading carries lux");

   // The tenth digit never exceeds nine
   a_tenth_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:28] <= TENTH_MAX)
      else $error("tenth digit above nine");

   // An accepted item blocks the input for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input ready straight after a transfer");

   // Range moves only on a finished item or a configuration write
   a_range_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_xfer && state_ff != ST_FINISH |=> $stable(range_ff))
      else $error("range changed outside finish or write");

   // A reported range is the one now in force
   a_range_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_free && !csr_xfer |=> rsp_tdata[33:32] == range_ff)
      else $error("reported range differs from state");

endmodule

// ===== tb/sv/lux_convert_auto_range_core_tb.sv =====
module lux_convert_auto_range_core_tb;
   import lca_pkg::*;

   localparam int SETTLE_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT    = 3000;
   localparam int SEGMENTS          = 12;
   localparam int ITEMS_PER_SEGMENT = 92;

   typedef struct packed {
      logic [WHOLE_W-1:0] whole;
      logic [TENTH_W-1:0] tenth;
      logic [RANGE_W-1:0] range_idx;
      logic               valid;
   } lux_reading_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [COUNT_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor state and scoreboard
   logic [CSR_DATA_W-1:0]  cur_res = 5'd12;
   logic [RANGE_W-1:0]     cur_range = RANGE_RESET;
   logic [COUNT_W-1:0]     pending_counts[$];
   lux_reading_type        expected_readings[$];

   int send_idle_pct = 22;
   int recv_idle_pct = 56;
   int queued_total = 0;
   int accepted_total = 0;
   int readings_seen = 0;
   int zero_counts = 0;
   int range_moves = 0;
   int csr_writes = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   lux_convert_auto_range_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Full-scale lux for a range index
   function automatic logic [PRODUCT_W-1:0] full_scale(input logic [RANGE_W-1:0] idx);
      logic [PRODUCT_W-1:0] lux;
      case (idx)
         2'd0:    lux = 32'd1000;
         2'd1:    lux = 32'd4000;
         2'd2:    lux = 32'd16000;
         default: lux = 32'd64000;
      endcase
      return lux;
   endfunction

   // Only shifts of 4, 8, 12 and 16 are taken
   function automatic logic res_supported(input logic [CSR_DATA_W-1:0] v);
      return (v != '0) && (v[1:0] == 2'b00) && (v <= 5'd16);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_bad_res();
      logic [CSR_DATA_W-1:0] v;
      do v = CSR_DATA_W'($urandom); while (res_supported(v));
      return v;
   endfunction

   // Mostly full-range counts, with zeros, dim readings and near-saturated ones
   function automatic logic [COUNT_W-1:0] draw_count();
      logic [COUNT_W-1:0] c;
      case ($urandom_range(9))
         0:       c = '0;
         1, 2:    c = COUNT_W'($urandom_range(255, 1));
         3:       c = 16'hffff - COUNT_W'($urandom_range(255));
         default: c = COUNT_W'($urandom);
      endcase
      return c;
   endfunction

   // Work out the reading for one count and advance the range
   task automatic predict_conversion(input logic [COUNT_W-1:0] count);
      logic [PRODUCT_W-1:0] product;
      logic [PRODUCT_W-1:0] whole;
      logic [PRODUCT_W-1:0] tenth;
      logic [PRODUCT_W-1:0] target;
      logic [RANGE_W-1:0]   chosen;
      lux_reading_type      r;
      r = '0;
      if (count == '0) begin
         // zero count: flag invalid, range stays put
         r.range_idx = cur_range;
         zero_counts++;
      end else begin
         product = PRODUCT_W'(count) * full_scale(cur_range);
         whole   = product >> cur_res;
         tenth   = ((product & 32'h0000_ffff) * 10) >> cur_res;
         if (tenth > PRODUCT_W'(TENTH_MAX)) tenth = PRODUCT_W'(TENTH_MAX);
         // smallest range that holds the reading plus a fifth, top range as ceiling
         target = whole + whole / 5;
         chosen = RANGE_TOP;
         for (int k = int'(RANGE_TOP) - 1; k >= 0; k--) begin
            if (target <= full_scale(RANGE_W'(k))) chosen = RANGE_W'(k);
         end
         if (chosen != cur_range) range_moves++;
         cur_range   = chosen;
         r.whole     = whole[WHOLE_W-1:0];
         r.tenth     = tenth[TENTH_W-1:0];
         r.range_idx = chosen;
         r.valid     = 1'b1;
      end
      expected_readings.push_back(r);
   endtask

   task automatic queue_count(input logic [COUNT_W-1:0] count);
      pending_counts.push_back(count);
      queued_total++;
   endtask

   // Hold until every queued count is through and its reading is back, then settle
   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_total != queued_total || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; mirror it into the predictor at the transfer
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RESOLUTION:   if (res_supported(val)) cur_res = val;
         CSR_RANGE_PRESET: cur_range = val[RANGE_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Force a starting range, send one count and drain
   task automatic probe(input logic [CSR_DATA_W-1:0] preset, input logic [COUNT_W-1:0] count);
      write_reg(CSR_RANGE_PRESET, preset);
      queue_count(count);
      wait_idle();
   endtask

   // Request driver: present counts from the queue, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_conversion(req_tdata);
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_counts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_counts.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: stall at random, check each transfer against the oldest reading
   always @(posedge clock) begin
      lux_reading_type got;
      lux_reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.whole     = rsp_tdata[27:0];
            got.tenth     = rsp_tdata[31:28];
            got.range_idx = rsp_tdata[33:32];
            got.valid     = rsp_tuser;
            readings_seen++;
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected reading: whole=%0d tenth=%0d range=%0d valid=%0b",
                           $realtime, got.whole, got.tenth, got.range_idx, got.valid);
            end else begin
               want = expected_readings.pop_front();
               if (got.whole !== want.whole || got.tenth !== want.tenth ||
                   got.range_idx !== want.range_idx || got.valid !== want.valid) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("[%0t] reading %0d: want %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                              $realtime, readings_seen, want.whole, want.tenth,
                              want.range_idx, want.valid, got.whole, got.tenth,
                              got.range_idx, got.valid);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: give up after a long stretch with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 12-bit shift, 4000 lux range
      queue_count(16'd0);
      queue_count(16'd1);
      queue_count(16'hffff);
      wait_idle();

      // Lowest range and shortest shift: tenth saturates, range jumps to the top
      write_reg(CSR_RESOLUTION, 5'd4);
      write_reg(CSR_RANGE_PRESET, 5'd0);
      queue_count(16'hffff);
      queue_count(16'hffff);
      queue_count(16'd0);
      queue_count(16'd1);
      wait_idle();

      // Unsupported shifts are dropped, before and after setting the longest shift
      write_reg(CSR_RESOLUTION, 5'd0);
      write_reg(CSR_RESOLUTION, 5'd31);
      write_reg(CSR_RESOLUTION, 5'd3);
      write_reg(CSR_RESOLUTION, 5'd17);
      write_reg(CSR_RESOLUTION, 5'd16);
      write_reg(CSR_RESOLUTION, 5'd20);

      // Range choice either side of each boundary, starting from the top range
      probe(5'd3, 16'd855);
      probe(5'd3, 16'd856);
      probe(5'd3, 16'd3415);
      probe(5'd3, 16'd3416);
      probe(5'd3, 16'd13655);
      probe(5'd3, 16'd13656);
      // upper preset bits are ignored
      probe(5'b11110, 16'hffff);

      write_reg(CSR_RESOLUTION, 5'd8);
      write_reg(CSR_RANGE_PRESET, 5'b10101);
      queue_count(16'h8000);
      queue_count(16'h5555);
      queue_count(16'haaaa);
      wait_idle();

      // Random segments, each with fresh settings
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 4) begin
            send_idle_pct <= 56;
            recv_idle_pct <= 22;
         end else if (seg == 8) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         write_reg(CSR_RESOLUTION, CSR_DATA_W'(4 * (seg % 4 + 1)));
         write_reg(CSR_RESOLUTION, draw_bad_res());
         write_reg(CSR_RANGE_PRESET, {3'($urandom), 2'((seg * 3) % 4)});
         for (int n = 0; n < ITEMS_PER_SEGMENT; n++) queue_count(draw_count());
         wait_idle();
      end

      $display("Ran %0d conversions (%0d zero counts, %0d range moves) over %0d register writes,",
               readings_seen, zero_counts, range_moves, csr_writes);
      $display("all four shifts and ranges, with and without stalls; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
